// ===== rtl/btc_pkg.sv =====
// ----------------------------------------------------------------------------
// btc_pkg
// Shared types, constants and helpers of the block transposition cipher.
// ----------------------------------------------------------------------------
package btc_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned KEY_LEN_W       = 4;
  localparam int unsigned NUM_KEY_DIGITS  = 9;
  localparam int unsigned KEY_DIGITS_W    = NUM_KEY_DIGITS * DIGIT_W;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned CFG_DATA_W      = KEY_DIGITS_W;
  localparam int unsigned MAX_KEY_LEN_DEF = 9;

  localparam logic [KEY_LEN_W-1:0]    KEY_LENGTH_RST  = 4'd9;
  localparam logic [KEY_DIGITS_W-1:0] KEY_DIGITS_RST  = 36'h987654321;
  localparam logic [BYTE_W-1:0]       PAD_BYTE_RST    = 8'h20;
  localparam logic                    DECODE_MODE_RST = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LENGTH  = 2'd0,
    CFG_KEY_DIGITS  = 2'd1,
    CFG_PAD_BYTE    = 2'd2,
    CFG_DECODE_MODE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              segment_last;
    logic              message_last;
    logic              key_bad;
  } out_item_t;

  // Selection control broadcast to every cell while a segment is emitted.
  typedef struct packed {
    logic [DIGIT_W-1:0] pos_digit;
    logic               key_bad;
    logic               decode;
  } sel_ctrl_t;

  // Key digit j; digits past the ninth read as zero.
  function automatic logic [DIGIT_W-1:0] key_digit(
    input logic [KEY_DIGITS_W-1:0] keys,
    input int unsigned             j
  );
    logic [DIGIT_W-1:0] d;
    d = '0;
    for (int unsigned i = 0; i < NUM_KEY_DIGITS; i++) begin
      if (i == j) begin
        d = keys[i*DIGIT_W +: DIGIT_W];
      end
    end
    return d;
  endfunction

endpackage

// ===== rtl/btc_stream_if.sv =====
// ----------------------------------------------------------------------------
// btc_stream_if
// Valid/ready channel carrying one item per request.
// ----------------------------------------------------------------------------
interface btc_stream_if #(
  parameter type item_t = logic
) ();

  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/btc_key_check.sv =====
// ----------------------------------------------------------------------------
// btc_key_check
// Derives the segment length from the key length, clamped to 1..MaxKeyLen, and
// flags a key whose length is out of range or whose digits are not a permutation of 1..length.
// ----------------------------------------------------------------------------
module btc_key_check #(
  parameter int unsigned MaxKeyLen = btc_pkg::MAX_KEY_LEN_DEF,
  parameter int unsigned CntW      = $clog2(MaxKeyLen + 1)
) (
  input  logic [btc_pkg::KEY_LEN_W-1:0]    key_length_i,
  input  logic [btc_pkg::KEY_DIGITS_W-1:0] key_digits_i,
  output logic [CntW-1:0]                  seg_len_o,
  output logic                             key_bad_o
);
  import btc_pkg::*;

  localparam int unsigned CmpW = KEY_LEN_W + 1;

  logic [CmpW-1:0]    kl_ext;
  logic               len_bad;
  logic [CntW-1:0]    len;
  logic [MaxKeyLen:0] seen_set;
  logic [MaxKeyLen:0] mask;
  logic               range_bad;
  logic [DIGIT_W-1:0] d;

  assign kl_ext = CmpW'(key_length_i);

  always_comb begin
    len_bad = 1'b0;
    if (kl_ext == '0) begin
      len     = CntW'(1);
      len_bad = 1'b1;
    end else if (kl_ext > CmpW'(MaxKeyLen)) begin
      len     = CntW'(MaxKeyLen);
      len_bad = 1'b1;
    end else begin
      len = CntW'(kl_ext);
    end
  end

  // Every digit in range and all of 1..len covered means no repeats.
  always_comb begin
    seen_set  = '0;
    mask      = '0;
    range_bad = 1'b0;
    d         = '0;
    for (int unsigned j = 0; j < MaxKeyLen; j++) begin
      d = key_digit(key_digits_i, j);
      if (CntW'(j) < len) begin
        if (d == '0 || CmpW'(d) > CmpW'(len)) begin
          range_bad = 1'b1;
        end
        for (int unsigned i = 1; i <= MaxKeyLen; i++) begin
          if (CmpW'(d) == CmpW'(i)) begin
            seen_set[i] = 1'b1;
          end
        end
      end
    end
    for (int unsigned i = 1; i <= MaxKeyLen; i++) begin
      mask[i] = (CmpW'(i) <= CmpW'(len));
    end
  end

  assign seg_len_o = len;
  assign key_bad_o = len_bad | range_bad | (seen_set != mask);

endmodule

// ===== rtl/btc_cell.sv =====
// ----------------------------------------------------------------------------
// btc_cell
// One slot of the segment: holds a byte, takes its key digit as an input, and passes the
// selected byte along the chain toward the output.
// ----------------------------------------------------------------------------
module btc_cell #(
  parameter int unsigned CellIdx = 0,
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CntW    = 4
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [IdxW-1:0]                wr_idx_i,
  input  logic [btc_pkg::BYTE_W-1:0]     wr_byte_i,
  input  logic [CntW-1:0]                filled_i,
  input  logic [CntW-1:0]                seg_len_i,
  input  logic [btc_pkg::BYTE_W-1:0]     pad_i,
  input  logic [btc_pkg::DIGIT_W-1:0]    digit_i,
  input  logic [IdxW-1:0]                pos_i,
  input  btc_pkg::sel_ctrl_t             ctrl_i,
  input  logic [btc_pkg::BYTE_W-1:0]     chain_i,
  output logic [btc_pkg::BYTE_W-1:0]     chain_o
);
  import btc_pkg::*;

  localparam int unsigned CmpW = DIGIT_W + 1;

  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] value;
  logic              in_seg;
  logic              hit;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_idx_i == IdxW'(CellIdx)) begin
      byte_q <= wr_byte_i;
    end
  end

  // Slots not filled in this segment read as the pad byte.
  assign value  = (filled_i > CntW'(CellIdx)) ? byte_q : pad_i;
  assign in_seg = (seg_len_i > CntW'(CellIdx));

  always_comb begin
    if (ctrl_i.key_bad) begin
      hit = (pos_i == IdxW'(CellIdx));
    end else if (ctrl_i.decode) begin
      hit = (CmpW'(digit_i) == CmpW'(pos_i) + CmpW'(1));
    end else begin
      hit = (CmpW'(ctrl_i.pos_digit) == CmpW'(CellIdx + 1));
    end
  end

  assign chain_o = (in_seg && hit) ? value : chain_i;

endmodule

// ===== rtl/block_transposition_cipher.sv =====
// ----------------------------------------------------------------------------
// block_transposition_cipher
// Permutation transposition cipher over segments of key-length bytes.
// ----------------------------------------------------------------------------
// Bytes enter one per cycle and are stored in a row of cells, one cell per
// segment slot. When a segment is full, or a byte marked end_of_message
// arrives, the input stalls and the segment is sent out one byte per cycle
// unless the output applies back-pressure; unfilled slots are sent as
// pad_byte. No byte of the next segment is taken until the last one is sent:
// the cell row has one shared write port and one read path. Encode gives
// out[j] = in[key[j]-1], decode the inverse; a bad key sends the segment
// unpermuted with key_bad set. Write configuration only while idle.
// ----------------------------------------------------------------------------
module block_transposition_cipher #(
  parameter int unsigned MaxKeyLen = btc_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  btc_stream_if.sink                       in_i,
  btc_stream_if.source                     out_o,
  input  logic                             cfg_we_i,
  input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [btc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import btc_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxKeyLen);
  localparam int unsigned CntW = $clog2(MaxKeyLen + 1);

  logic [KEY_LEN_W-1:0]    key_length_q;
  logic [KEY_DIGITS_W-1:0] key_digits_q;
  logic [BYTE_W-1:0]       pad_byte_q;
  logic                    decode_mode_q;

  state_e            state_q, state_d;
  logic [CntW-1:0]   fill_q, fill_d;
  logic [IdxW-1:0]   emit_q, emit_d;
  logic              eom_q, eom_d;

  logic [CntW-1:0]   seg_len;
  logic              key_bad;
  logic [IdxW-1:0]   len_m1;
  logic [IdxW-1:0]   wr_pos;
  logic [CntW-1:0]   wr_next;
  logic              in_acc;
  logic              out_acc;
  logic              seg_end;
  in_item_t          in_item;
  out_item_t         out_item;
  sel_ctrl_t         ctrl;

  logic [DIGIT_W-1:0] digit [MaxKeyLen];
  logic [BYTE_W-1:0]  chain [MaxKeyLen+1];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_length_q  <= KEY_LENGTH_RST;
      key_digits_q  <= KEY_DIGITS_RST;
      pad_byte_q    <= PAD_BYTE_RST;
      decode_mode_q <= DECODE_MODE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KEY_LENGTH:  key_length_q  <= cfg_data_i[KEY_LEN_W-1:0];
        CFG_KEY_DIGITS:  key_digits_q  <= cfg_data_i[KEY_DIGITS_W-1:0];
        CFG_PAD_BYTE:    pad_byte_q    <= cfg_data_i[BYTE_W-1:0];
        CFG_DECODE_MODE: decode_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  btc_key_check #(
    .MaxKeyLen (MaxKeyLen),
    .CntW      (CntW)
  ) u_key_check (
    .key_length_i (key_length_q),
    .key_digits_i (key_digits_q),
    .seg_len_o    (seg_len),
    .key_bad_o    (key_bad)
  );

  assign in_item  = in_i.payload;
  assign in_i.ready = (state_q == ST_FILL);
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_o.valid = (state_q == ST_EMIT);
  assign out_acc  = out_o.valid && out_o.ready;

  assign len_m1  = IdxW'(seg_len - CntW'(1));
  // Overwrite the last slot when the key length shrank below the fill level.
  assign wr_pos  = (fill_q >= seg_len) ? len_m1 : IdxW'(fill_q);
  assign wr_next = CntW'(wr_pos) + CntW'(1);
  assign seg_end = (emit_q == len_m1);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    emit_d  = emit_q;
    eom_d   = eom_q;
    unique case (state_q)
      ST_FILL: begin
        if (in_acc) begin
          fill_d = wr_next;
          if (in_item.end_of_message || wr_next >= seg_len) begin
            eom_d   = in_item.end_of_message;
            emit_d  = '0;
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (seg_end) begin
            fill_d  = '0;
            state_d = ST_FILL;
          end else begin
            emit_d = emit_q + IdxW'(1);
          end
        end
      end
      default: state_d = ST_FILL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      fill_q  <= '0;
      emit_q  <= '0;
      eom_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      emit_q  <= emit_d;
      eom_q   <= eom_d;
    end
  end

  always_comb begin
    for (int unsigned k = 0; k < MaxKeyLen; k++) begin
      digit[k] = key_digit(key_digits_q, k);
    end
  end

  assign ctrl.pos_digit = digit[emit_q];
  assign ctrl.key_bad   = key_bad;
  assign ctrl.decode    = decode_mode_q;

  assign chain[0] = pad_byte_q;

  for (genvar k = 0; k < MaxKeyLen; k++) begin : g_cell
    btc_cell #(
      .CellIdx (k),
      .IdxW    (IdxW),
      .CntW    (CntW)
    ) u_cell (
      .clk_i     (clk_i),
      .wr_en_i   (in_acc),
      .wr_idx_i  (wr_pos),
      .wr_byte_i (in_item.data_byte),
      .filled_i  (fill_q),
      .seg_len_i (seg_len),
      .pad_i     (pad_byte_q),
      .digit_i   (digit[k]),
      .pos_i     (emit_q),
      .ctrl_i    (ctrl),
      .chain_i   (chain[k]),
      .chain_o   (chain[k+1])
    );
  end

  assign out_item.out_byte     = chain[MaxKeyLen];
  assign out_item.segment_last = seg_end;
  assign out_item.message_last = seg_end && eom_q;
  assign out_item.key_bad      = key_bad;
  assign out_o.payload         = out_item;

endmodule
